[sv/tdpc_pkg.sv]
package tdpc_pkg;

    localparam int COORD_W   = 32;
    localparam int PLANE_W   = 31;
    localparam int COLOR_W   = 24;
    localparam int MAG_W     = 33;              // magnitude of a coordinate difference
    localparam int DIFF_W    = 34;              // signed plane/z difference
    localparam int DIV_STEPS = MAG_W;           // quotient bits, one per cycle
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int TDATA_W   = 9 * COORD_W + COLOR_W;   // 312, whole bytes

    localparam logic CFG_NEAR = 1'b0;
    localparam logic CFG_FAR  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vtx;

    typedef t_vtx [2:0] t_tri;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_MUL0,
        ST_DIV0,
        ST_MUL1,
        ST_DIV1,
        ST_WRITE,
        ST_NEXT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_in;      // take a new triangle, start near stage
        logic mul;          // form products for one edge cut
        logic sel;          // which cut: 0 edge odd-f0, 1 edge odd-f1
        logic div_step;     // one quotient bit
        logic write;        // store the stage's triangles
        logic next_s1;      // load next near-stage triangle into far stage
        logic emit_adv;     // result transaction done
    } t_cmd;

    typedef struct packed {
        logic need_cut;     // one or two vertices outside
        logic div_last;     // final quotient bit this cycle
        logic more_s1;      // a near-stage triangle waits for the far stage
        logic res_any;      // at least one result stored
        logic emit_last;    // current result is the final one
    } t_status;

endpackage

[sv/tdpc_ctrl.sv]
module tdpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  tdpc_pkg::t_status i_status,
    output tdpc_pkg::t_cmd    o_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid
);

    tdpc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdpc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdpc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = tdpc_pkg::ST_CLASS;
            end
            tdpc_pkg::ST_CLASS: begin
                n_state = i_status.need_cut ? tdpc_pkg::ST_MUL0 : tdpc_pkg::ST_WRITE;
            end
            tdpc_pkg::ST_MUL0: n_state = tdpc_pkg::ST_DIV0;
            tdpc_pkg::ST_DIV0: begin
                if (i_status.div_last) n_state = tdpc_pkg::ST_MUL1;
            end
            tdpc_pkg::ST_MUL1: n_state = tdpc_pkg::ST_DIV1;
            tdpc_pkg::ST_DIV1: begin
                if (i_status.div_last) n_state = tdpc_pkg::ST_WRITE;
            end
            tdpc_pkg::ST_WRITE: n_state = tdpc_pkg::ST_NEXT;
            tdpc_pkg::ST_NEXT: begin
                if (i_status.more_s1) begin
                    n_state = tdpc_pkg::ST_CLASS;
                end else if (i_status.res_any) begin
                    n_state = tdpc_pkg::ST_EMIT;
                end else begin
                    n_state = tdpc_pkg::ST_IDLE;
                end
            end
            tdpc_pkg::ST_EMIT: begin
                if (i_out_ready && i_status.emit_last) n_state = tdpc_pkg::ST_IDLE;
            end
            default: n_state = tdpc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            tdpc_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            tdpc_pkg::ST_MUL0: o_cmd.mul = 1'b1;
            tdpc_pkg::ST_DIV0: o_cmd.div_step = 1'b1;
            tdpc_pkg::ST_MUL1: begin
                o_cmd.mul = 1'b1;
                o_cmd.sel = 1'b1;
            end
            tdpc_pkg::ST_DIV1: begin
                o_cmd.div_step = 1'b1;
                o_cmd.sel      = 1'b1;
            end
            tdpc_pkg::ST_WRITE: o_cmd.write = 1'b1;
            tdpc_pkg::ST_NEXT: o_cmd.next_s1 = i_status.more_s1;
            tdpc_pkg::ST_EMIT: begin
                o_out_valid    = 1'b1;
                o_cmd.emit_adv = i_out_ready;
            end
            default: ;
        endcase
    end

endmodule

[sv/tdpc_datapath.sv]
module tdpc_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tdpc_pkg::t_cmd                      i_cmd,
    output tdpc_pkg::t_status                   o_status,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [tdpc_pkg::PLANE_W-1:0]        i_cfg_data,
    input  logic [tdpc_pkg::TDATA_W-1:0]        i_in_data,
    output logic [tdpc_pkg::TDATA_W-1:0]        o_out_data,
    output logic                                o_out_last
);

    localparam int CW = tdpc_pkg::COORD_W;
    localparam int MW = tdpc_pkg::MAG_W;
    localparam int DW = tdpc_pkg::DIFF_W;
    localparam logic [tdpc_pkg::PLANE_W-1:0] NEAR_RST =
        tdpc_pkg::PLANE_W'((64'd1 << FRAC_BITS) / 5);
    localparam logic [tdpc_pkg::PLANE_W-1:0] FAR_RST =
        tdpc_pkg::PLANE_W'(64'd100 << FRAC_BITS);

    logic [tdpc_pkg::PLANE_W-1:0] r_near, r_far_z;
    tdpc_pkg::t_tri               r_work;
    logic [tdpc_pkg::COLOR_W-1:0] r_color;
    logic                         r_far;
    tdpc_pkg::t_tri               r_s1 [2];
    logic [1:0]                   r_n1;
    logic                         r_sidx;
    tdpc_pkg::t_tri               r_res [4];
    logic [2:0]                   r_nres;
    logic [1:0]                   r_k;
    logic signed [CW-1:0]         r_ptx [2];
    logic signed [CW-1:0]         r_pty [2];
    // divider
    logic [MW-1:0]                r_rx, r_ry, r_lx, r_ly, r_qx, r_qy, r_d;
    logic                         r_negx, r_negy;
    logic signed [CW-1:0]         r_vfx, r_vfy;
    logic [tdpc_pkg::DCNT_W-1:0]  r_dcnt;

    // ---------------- classification ----------------
    logic [tdpc_pkg::PLANE_W-1:0] plane;
    logic [2:0]                   outside, pick;
    logic [1:0]                   cnt, odd, f0, f1;
    logic signed [CW:0]           plane_s;

    assign plane   = r_far ? r_far_z : r_near;
    assign plane_s = $signed({2'b00, plane});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            outside[i] = r_far ? ($signed({r_work[i].z[CW-1], r_work[i].z}) > plane_s)
                               : ($signed({r_work[i].z[CW-1], r_work[i].z}) < plane_s);
        end
        cnt  = 2'($countones(outside));
        pick = (cnt == 2'd1) ? outside : ~outside;
        if (pick[0]) begin
            odd = 2'd0; f0 = 2'd1; f1 = 2'd2;
        end else if (pick[1]) begin
            odd = 2'd1; f0 = 2'd0; f1 = 2'd2;
        end else begin
            odd = 2'd2; f0 = 2'd0; f1 = 2'd1;
        end
    end

    // ---------------- edge products ----------------
    tdpc_pkg::t_vtx        vf, vo;
    logic signed [CW:0]    dvx, dvy;
    logic signed [DW-1:0]  ndz, dz;
    logic [MW-1:0]         mdx, mdy, mndz, mdz;
    logic [2*MW-1:0]       prodx, prody;

    always_comb begin
        vf    = r_work[i_cmd.sel ? f1 : f0];
        vo    = r_work[odd];
        dvx   = $signed({vo.x[CW-1], vo.x}) - $signed({vf.x[CW-1], vf.x});
        dvy   = $signed({vo.y[CW-1], vo.y}) - $signed({vf.y[CW-1], vf.y});
        ndz   = $signed({3'b000, plane}) - $signed({{2{vf.z[CW-1]}}, vf.z});
        dz    = $signed({{2{vo.z[CW-1]}}, vo.z}) - $signed({{2{vf.z[CW-1]}}, vf.z});
        mdx   = dvx[CW] ? MW'(-dvx) : MW'(dvx);
        mdy   = dvy[CW] ? MW'(-dvy) : MW'(dvy);
        mndz  = ndz[DW-1] ? MW'(-ndz) : MW'(ndz);
        mdz   = dz[DW-1] ? MW'(-dz) : MW'(dz);
        prodx = mdx * mndz;
        prody = mdy * mndz;
    end

    // ---------------- restoring divide, one bit a cycle ----------------
    logic [MW:0]          rsx, rsy;
    logic                 gex, gey;
    logic [MW-1:0]        nrx, nry, nqx, nqy;
    logic signed [CW+1:0] ptx, pty;

    always_comb begin
        rsx = {r_rx, r_lx[MW-1]};
        rsy = {r_ry, r_ly[MW-1]};
        gex = rsx >= {1'b0, r_d};
        gey = rsy >= {1'b0, r_d};
        nrx = gex ? MW'(rsx - {1'b0, r_d}) : MW'(rsx);
        nry = gey ? MW'(rsy - {1'b0, r_d}) : MW'(rsy);
        nqx = {r_qx[MW-2:0], gex};
        nqy = {r_qy[MW-2:0], gey};
        if (r_d == '0) begin
            ptx = (CW+2)'(r_vfx);
            pty = (CW+2)'(r_vfy);
        end else begin
            ptx = r_negx ? (CW+2)'(r_vfx) - $signed({1'b0, nqx})
                         : (CW+2)'(r_vfx) + $signed({1'b0, nqx});
            pty = r_negy ? (CW+2)'(r_vfy) - $signed({1'b0, nqy})
                         : (CW+2)'(r_vfy) + $signed({1'b0, nqy});
        end
    end

    // ---------------- stage result assembly ----------------
    tdpc_pkg::t_vtx p0, p1;
    tdpc_pkg::t_tri tri_a, tri_b;
    logic [1:0]     nnew;

    always_comb begin
        p0 = '{z: $signed({1'b0, plane}), y: r_pty[0], x: r_ptx[0]};
        p1 = '{z: $signed({1'b0, plane}), y: r_pty[1], x: r_ptx[1]};
        tri_a = r_work;
        tri_b = r_work;
        case (cnt)
            2'd0: nnew = 2'd1;
            2'd1: begin
                tri_a[odd] = p0;
                tri_b[odd] = p1;
                tri_b[f0]  = p0;
                nnew       = 2'd2;
            end
            2'd2: begin
                tri_a[f0] = p0;
                tri_a[f1] = p1;
                nnew      = 2'd1;
            end
            default: nnew = 2'd0;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near  <= NEAR_RST;
            r_far_z <= FAR_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == tdpc_pkg::CFG_NEAR) begin
                r_near <= i_cfg_data;
            end else begin
                r_far_z <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far  <= 1'b0;
            r_n1   <= '0;
            r_sidx <= 1'b0;
            r_nres <= '0;
            r_k    <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_far  <= 1'b0;
                r_n1   <= '0;
                r_sidx <= 1'b0;
                r_nres <= '0;
                r_k    <= '0;
            end
            if (i_cmd.mul) r_dcnt <= '0;
            if (i_cmd.div_step) r_dcnt <= r_dcnt + 1'b1;
            if (i_cmd.write) begin
                if (r_far) begin
                    r_nres <= r_nres + {1'b0, nnew};
                end else begin
                    r_n1 <= nnew;
                end
            end
            if (i_cmd.next_s1) begin
                r_far  <= 1'b1;
                r_sidx <= r_far ? 1'b1 : 1'b0;
            end
            if (i_cmd.emit_adv) r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_work  <= tdpc_pkg::t_tri'(i_in_data[9*CW-1:0]);
            r_color <= i_in_data[tdpc_pkg::TDATA_W-1:9*CW];
        end
        if (i_cmd.next_s1) begin
            r_work <= r_far ? r_s1[1] : r_s1[0];
        end
        if (i_cmd.mul) begin
            r_rx   <= prodx[2*MW-1:MW];
            r_lx   <= prodx[MW-1:0];
            r_ry   <= prody[2*MW-1:MW];
            r_ly   <= prody[MW-1:0];
            r_d    <= mdz;
            r_qx   <= '0;
            r_qy   <= '0;
            r_negx <= dvx[CW] ^ ndz[DW-1] ^ dz[DW-1];
            r_negy <= dvy[CW] ^ ndz[DW-1] ^ dz[DW-1];
            r_vfx  <= vf.x;
            r_vfy  <= vf.y;
        end
        if (i_cmd.div_step) begin
            r_rx <= nrx;
            r_ry <= nry;
            r_lx <= {r_lx[MW-2:0], 1'b0};
            r_ly <= {r_ly[MW-2:0], 1'b0};
            r_qx <= nqx;
            r_qy <= nqy;
            if (o_status.div_last) begin
                r_ptx[i_cmd.sel] <= ptx[CW-1:0];
                r_pty[i_cmd.sel] <= pty[CW-1:0];
            end
        end
        if (i_cmd.write) begin
            if (r_far) begin
                if (nnew != 2'd0) r_res[r_nres[1:0]] <= tri_a;
                if (nnew == 2'd2) r_res[2'(r_nres[1:0] + 2'd1)] <= tri_b;
            end else begin
                r_s1[0] <= tri_a;
                r_s1[1] <= tri_b;
            end
        end
    end

    always_comb begin
        o_status.need_cut  = (cnt == 2'd1) || (cnt == 2'd2);
        o_status.div_last  = (r_dcnt == tdpc_pkg::DCNT_W'(tdpc_pkg::DIV_STEPS - 1));
        o_status.more_s1   = r_far ? (!r_sidx && r_n1 == 2'd2) : (r_n1 != 2'd0);
        o_status.res_any   = (r_nres != 3'd0);
        o_status.emit_last = ({1'b0, r_k} + 3'd1) == r_nres;
    end

    assign o_out_data = {r_color, r_res[r_k]};
    assign o_out_last = o_status.emit_last;

endmodule

[sv/triangle_depth_plane_clipper_unit.sv]
// Channel  | Direction | Handshake                 | Payload
// s        | in        | i_s_tvalid / o_s_tready   | i_s_tdata: triangle + color
// m        | out       | o_m_tvalid / i_m_tready   | o_m_tdata + o_m_tlast
// cfg      | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One triangle at a time. Each stage that cuts runs classify, a cut of each edge at the
// odd vertex (multiply, then divide steps on a shared restoring divider), write and
// hand-off; a stage that cuts nothing runs classify, write and hand-off. Up to three
// stages run (near, then far on each near result); after them each result is sent as
// its own transaction.
// Reset (synchronous, active low) restores the default planes and empties the unit.
// A stalled result transaction holds; no new triangle is taken until all are sent.
module triangle_depth_plane_clipper_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata, low bit up: ax, ay, az, bx, by_coord, bz, cx, cy, cz, face_color
    input  logic [tdpc_pkg::TDATA_W-1:0]         i_s_tdata,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata, low bit up: out_ax, out_ay, out_az, out_bx, out_by, out_bz,
    //                    out_cx, out_cy, out_cz, out_color
    output logic [tdpc_pkg::TDATA_W-1:0]         o_m_tdata,
    output logic                                 o_m_tlast,   // last_triangle
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // config: index 0 near_plane_z, index 1 far_plane_z
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_index,
    input  logic [tdpc_pkg::PLANE_W-1:0]         i_cfg_data
);

    tdpc_pkg::t_cmd    cmd;
    tdpc_pkg::t_status status;

    // config writes are always accepted
    assign o_cfg_ready = 1'b1;

    tdpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid)
    );

    tdpc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_tdata),
        .o_out_data  (o_m_tdata),
        .o_out_last  (o_m_tlast)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC         = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 300;   // wait after the queue empties; covers the worst triangle plus results

    typedef struct {
        logic signed [tdpc_pkg::COORD_W-1:0] c [9];   // ax ay az bx by bz cx cy cz
        logic [tdpc_pkg::COLOR_W-1:0]        color;
    } t_face;

    typedef struct {
        logic signed [tdpc_pkg::COORD_W-1:0] c [9];
        logic [tdpc_pkg::COLOR_W-1:0]        color;
        logic                                last;
    } t_clip_res;

    typedef logic signed [63:0] t_wide;
    typedef t_wide t_corner [3][3];

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic [tdpc_pkg::TDATA_W-1:0]     i_s_tdata = '0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [tdpc_pkg::TDATA_W-1:0]     o_m_tdata;
    logic                             o_m_tlast;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic                             i_cfg_index = tdpc_pkg::CFG_NEAR;
    logic [tdpc_pkg::PLANE_W-1:0]     i_cfg_data = '0;

    // model copy of the plane registers
    logic [tdpc_pkg::PLANE_W-1:0]     near_z;
    logic [tdpc_pkg::PLANE_W-1:0]     far_z;

    t_clip_res              clip_queue[$];
    int                     err_count = 0;
    int                     cycle_count = 0;
    int                     burst_left = 0;
    int                     stall_mode = 0;

    triangle_depth_plane_clipper_unit #(.FRAC_BITS(FRAC)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: any hang ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Prediction: edge cut, one clipping stage, then near and far in turn.
    // ------------------------------------------------------------------

    // vf + trunc(ndz * (vo - vf) / dz); product fits in 128 bits signed
    function automatic t_wide edge_lerp(t_wide vf, t_wide vo, t_wide ndz, t_wide dz);
        logic signed [127:0] prod;
        logic signed [127:0] quo;
        if (dz == 0)
            return vf;
        prod = 128'(signed'(vo - vf)) * 128'(signed'(ndz));
        quo  = prod / 128'(signed'(dz));   // SV division truncates toward zero
        return vf + t_wide'(quo);
    endfunction

    function automatic void cut_edge(input t_corner t, input int fi, input int oi,
                                     input t_wide plane, output t_wide pt[3]);
        t_wide ndz;
        t_wide dz;
        ndz = plane - t[fi][2];
        dz  = t[oi][2] - t[fi][2];
        pt[0] = edge_lerp(t[fi][0], t[oi][0], ndz, dz);
        pt[1] = edge_lerp(t[fi][1], t[oi][1], ndz, dz);
        pt[2] = plane;
    endfunction

    function automatic int clip_plane(input t_corner t, input t_wide plane,
                                      input bit far_side, output t_corner outp[2]);
        bit    outside[3];
        int    cnt;
        int    odd;
        int    f0;
        int    f1;
        t_wide p0[3];
        t_wide p1[3];
        cnt = 0; odd = 0; f0 = -1; f1 = -1;
        for (int i = 0; i < 3; i++) begin
            outside[i] = far_side ? (t[i][2] > plane) : (t[i][2] < plane);
            if (outside[i]) cnt++;
        end
        if (cnt == 0) begin
            outp[0] = t;
            return 1;
        end
        if (cnt == 3)
            return 0;
        for (int i = 0; i < 3; i++) begin
            if (outside[i] == (cnt == 1)) odd = i;
            else if (f0 < 0) f0 = i;
            else f1 = i;
        end
        cut_edge(t, f0, odd, plane, p0);
        cut_edge(t, f1, odd, plane, p1);
        if (cnt == 1) begin
            outp[0] = t;
            outp[1] = t;
            for (int j = 0; j < 3; j++) begin
                outp[0][odd][j] = p0[j];
                outp[1][odd][j] = p1[j];
                outp[1][f0][j]  = p0[j];
            end
            return 2;
        end
        outp[0] = t;
        for (int j = 0; j < 3; j++) begin
            outp[0][f0][j] = p0[j];
            outp[0][f1][j] = p1[j];
        end
        return 1;
    endfunction

    // Queues the clipped triangles this face is expected to produce.
    function automatic void predict_clip(input t_face f);
        t_corner   t;
        t_corner   near_out[2];
        t_corner   far_out[2];
        t_corner   res[$];
        t_clip_res r;
        int        n1;
        int        n2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                t[i][j] = t_wide'(f.c[i*3+j]);
        n1 = clip_plane(t, t_wide'({1'b0, near_z}), 1'b0, near_out);
        for (int i = 0; i < n1; i++) begin
            n2 = clip_plane(near_out[i], t_wide'({1'b0, far_z}), 1'b1, far_out);
            for (int j = 0; j < n2; j++)
                if (res.size() < 4) res.push_back(far_out[j]);
        end
        foreach (res[k]) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    r.c[i*3+j] = res[k][i][j][tdpc_pkg::COORD_W-1:0];
            r.color = f.color;
            r.last  = (k == res.size() - 1);
            clip_queue.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern plus checker.
    // ------------------------------------------------------------------

    // stall_mode: 0 always ready, 1 random 50%, 2 mostly stalled, 3 periodic
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= 1'($urandom_range(1));
                2: i_m_tready <= ($urandom_range(7) == 0);
                default: i_m_tready <= (cycle_count % 5) < 3;
            endcase
            if ((cycle_count % 97) == 0)
                stall_mode <= $urandom_range(3);
        end
    end

    always @(posedge i_clk) begin
        t_clip_res want;
        logic signed [tdpc_pkg::COORD_W-1:0] got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (clip_queue.size() == 0) begin
                report_mismatch("unexpected clipped triangle");
            end else begin
                want = clip_queue.pop_front();
                for (int k = 0; k < 9; k++) begin
                    got = o_m_tdata[k*tdpc_pkg::COORD_W +: tdpc_pkg::COORD_W];
                    if (got !== want.c[k])
                        report_mismatch($sformatf("coord %0d got %0d want %0d",
                                                  k, got, want.c[k]));
                end
                if (o_m_tdata[9*tdpc_pkg::COORD_W +: tdpc_pkg::COLOR_W] !== want.color)
                    report_mismatch($sformatf("color got %h want %h",
                        o_m_tdata[9*tdpc_pkg::COORD_W +: tdpc_pkg::COLOR_W], want.color));
                if (o_m_tlast !== want.last)
                    report_mismatch($sformatf("tlast got %b want %b", o_m_tlast, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sends one face; gaps between random-length bursts.
    task automatic send_face(input t_face f);
        logic [tdpc_pkg::TDATA_W-1:0] pkt;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        for (int k = 0; k < 9; k++)
            pkt[k*tdpc_pkg::COORD_W +: tdpc_pkg::COORD_W] = f.c[k];
        pkt[9*tdpc_pkg::COORD_W +: tdpc_pkg::COLOR_W] = f.color;
        i_s_tdata  <= pkt;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_clip(f);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (clip_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Only called while idle and drained.
    task automatic write_plane(input logic idx, input logic [tdpc_pkg::PLANE_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == tdpc_pkg::CFG_NEAR) near_z = val;
        else                           far_z  = val;
        @(posedge i_clk);
    endtask

    function automatic logic signed [tdpc_pkg::COORD_W-1:0] rand_z();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            // around the planes for interesting cuts
            0, 1, 2: return $signed({1'b0, near_z}) + $signed($urandom_range(2000000)) - 1000000;
            3, 4, 5: return $signed({1'b0, far_z}) + $signed($urandom_range(2000000)) - 1000000;
            6, 7:    return $signed({1'b0, near_z}) +
                            $signed($urandom_range(32'h7fff_ffff) % (far_z - near_z + 1));
            8:       return (($urandom_range(1) == 0) ? near_z : far_z);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_face rand_face();
        t_face f;
        for (int i = 0; i < 3; i++) begin
            f.c[i*3]   = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(2000000)) - 1000000;
            f.c[i*3+1] = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(2000000)) - 1000000;
            f.c[i*3+2] = rand_z();
        end
        f.color = tdpc_pkg::COLOR_W'($urandom);
        return f;
    endfunction

    function automatic t_face make_face(int x0, int y0, int z0, int x1, int y1, int z1,
                                        int x2, int y2, int z2, int col);
        t_face f;
        f.c[0] = x0; f.c[1] = y0; f.c[2] = z0;
        f.c[3] = x1; f.c[4] = y1; f.c[5] = z1;
        f.c[6] = x2; f.c[7] = y2; f.c[8] = z2;
        f.color = tdpc_pkg::COLOR_W'(col);
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default planes: pass, drop, single and double cut on each plane.
    task automatic test_directed_defaults();
        int one;
        int nz;
        int fz;
        one = 1 << FRAC;
        nz  = near_z;
        fz  = far_z;
        send_face(make_face(0, 0, one, one, 0, 2*one, 0, one, 3*one, 24'h123456));
        send_face(make_face(0, 0, -one, one, 0, -one, 0, one, 0, 24'hffffff));     // all near out
        send_face(make_face(0, 0, 200*one, 1, 2, 300*one, 3, 4, fz + 1, 24'h000000)); // all far out
        send_face(make_face(-one, one, -one, one, 0, 2*one, 0, one, 3*one, 24'ha5a5a5)); // v0 near out
        send_face(make_face(0, 0, one, one, -one, -one, 0, one, 3*one, 24'h5a5a5a));  // v1 near out
        send_face(make_face(0, 0, one, one, 0, 2*one, 7*one, -3*one, -2*one, 24'h010203)); // v2
        send_face(make_face(0, 0, -one, one, 0, -2*one, 0, one, 3*one, 24'h800001)); // two near out
        send_face(make_face(0, 0, 150*one, one, 0, 2*one, 0, one, 3*one, 24'h7f7f7f)); // one far out
        send_face(make_face(0, 0, 150*one, one, 9, 2*one, 5, one, 130*one, 24'h00ff00)); // two far
        // near cut then far cut on both pieces: four results
        send_face(make_face(0, 0, -50*one, 5*one, 0, 50*one, 0, 8*one, 160*one, 24'h0000ff));
        send_face(make_face(-100*one, 3*one, 200*one, 40*one, -9*one, 50*one,
                            7*one, 60*one, -20*one, 24'hff0000));
        // on the plane exactly: inside
        send_face(make_face(1, 2, nz, 3, 4, fz, 5, 6, nz, 24'h111111));
        // coordinate extremes
        send_face(make_face(32'h7fffffff, 32'h80000000, -one, 32'h80000000, 32'h7fffffff,
                            50*one, 32'h7fffffff, 32'h7fffffff, 200*one, 24'hfedcba));
        send_face(make_face(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                            32'h7fffffff, 32'h7fffffff, 0, 0, one, 24'h0f0f0f));
        send_face(make_face(32'hffffffff, 32'hffffffff, 32'h7fffffff, 0, 0, 32'h80000000,
                            32'h80000000, 32'h7fffffff, 2*one, 24'hf0f0f0));
        wait_drained();
    endtask

    // Plane extremes and inverted planes; every register written.
    task automatic test_plane_extremes();
        t_face f;
        write_plane(tdpc_pkg::CFG_NEAR, '0);
        write_plane(tdpc_pkg::CFG_FAR, '1);
        for (int i = 0; i < 8; i++) send_face(rand_face());
        f = make_face(1, 1, 32'h80000000, 2, 2, 32'h7fffffff, 3, 3, 0, 24'habcdef);
        send_face(f);
        wait_drained();
        // near beyond far: nothing should come out
        write_plane(tdpc_pkg::CFG_NEAR, 31'h4000_0000);
        write_plane(tdpc_pkg::CFG_FAR, 31'h0000_1000);
        for (int i = 0; i < 6; i++) send_face(rand_face());
        wait_drained();
        write_plane(tdpc_pkg::CFG_NEAR, '1);
        write_plane(tdpc_pkg::CFG_FAR, '1);
        for (int i = 0; i < 4; i++) send_face(rand_face());
        wait_drained();
    endtask

    // Random faces over a few plane settings.
    task automatic test_random_faces(input int count);
        logic [tdpc_pkg::PLANE_W-1:0] a;
        logic [tdpc_pkg::PLANE_W-1:0] b;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0) begin
                a = 31'd13107;
                b = 31'd6553600;
            end else begin
                a = tdpc_pkg::PLANE_W'($urandom_range(32'h0100_0000));
                b = a + tdpc_pkg::PLANE_W'($urandom_range(32'h2000_0000));
                if ($urandom_range(5) == 0) b = tdpc_pkg::PLANE_W'($urandom);   // may invert planes
            end
            write_plane(tdpc_pkg::CFG_NEAR, a);
            write_plane(tdpc_pkg::CFG_FAR, b);
            for (int i = 0; i < count / 6; i++) begin
                send_face(rand_face());
                // hold off until every expected result has arrived
                if (i == 20) wait_drained();
            end
            wait_drained();
        end
    endtask

    initial begin
        near_z = 31'd13107;
        far_z  = 31'd6553600;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_defaults();
        test_plane_extremes();
        test_random_faces(420);
        wait_drained();
        if (err_count == 0 && clip_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", err_count, clip_queue.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[triangle_depth_plane_clipper_unit.f]
sv/tdpc_pkg.sv
sv/tdpc_ctrl.sv
sv/tdpc_datapath.sv
sv/triangle_depth_plane_clipper_unit.sv
verif/tb_top.sv
